[design/sactc_pkg.sv]
// Shared types, register codes and constants for the set-associative cache tag controller.
package sactc_pkg;

    // Fixed field widths.
    localparam int ADDR_BITS     = 32;
    localparam int LAT_BITS      = 8;
    localparam int CNT_BITS      = 32;
    localparam int CFG_ADDR_BITS = 4;
    localparam int CFG_DATA_BITS = 32;

    // Access kinds carried by the operation field.
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_STORE = 1'b1;

    // Configuration register indexes, taken from paddr above the byte offset.
    typedef enum logic [1:0] {
        REG_ENABLE     = 2'd0,
        REG_LOOKUP_LAT = 2'd1,
        REG_READ_LAT   = 2'd2,
        REG_WRITE_LAT  = 2'd3
    } cfg_reg_t;

    // Register values after reset.
    localparam logic                RST_ENABLE     = 1'b1;
    localparam logic [LAT_BITS-1:0] RST_LOOKUP_LAT = 8'd1;
    localparam logic [LAT_BITS-1:0] RST_READ_LAT   = 8'd10;
    localparam logic [LAT_BITS-1:0] RST_WRITE_LAT  = 8'd10;

    // Controller states.
    typedef enum logic [1:0] {
        ST_CLEAR  = 2'd0,
        ST_IDLE   = 2'd1,
        ST_LOOKUP = 2'd2
    } ctrl_state_t;

    // Current configuration as seen by the datapath.
    typedef struct packed {
        logic                enable;
        logic [LAT_BITS-1:0] lookup_lat;
        logic [LAT_BITS-1:0] read_lat;
        logic [LAT_BITS-1:0] write_lat;
    } cfg_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clear_en;
        logic capture;
        logic commit;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clear_last;
        logic out_blocked;
    } dp_status_t;

endpackage

[design/set_assoc_cache_tag_controller_unit.sv]
// Top level of the set-associative write-back cache tag controller.
//
//   channel   direction  handshake               payload
//   config    in/out     psel/penable/pready     paddr, pwdata, prdata
//   request   in         req_valid/req_stall     operation, address
//   response  out        rsp_valid/rsp_stall     hit, writeback, latency, five counters
//
// A request is taken in the idle state, which reads its set row from the tag and
// line-state arrays; the lookup step then compares, updates the row and loads
// the result register. After reset a clearing pass zeroes the line state of one
// set per cycle with req_stall high; configuration writes are taken throughout.
// A stalled response holds the update step, and the next request is taken once the
// held result has been loaded into the result register.
// NUM_SETS and BLOCK_BYTES are powers of two.
module set_assoc_cache_tag_controller_unit #(
    parameter int NUM_SETS    = 8,
    parameter int NUM_WAYS    = 4,
    parameter int BLOCK_BYTES = 32
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [sactc_pkg::CFG_ADDR_BITS-1:0]   paddr,
    input  logic [sactc_pkg::CFG_DATA_BITS-1:0]   pwdata,
    output logic [sactc_pkg::CFG_DATA_BITS-1:0]   prdata,
    output logic                                  pready,
    input  logic                                  req_valid,
    output logic                                  req_stall,
    input  logic                                  operation,
    input  logic [sactc_pkg::ADDR_BITS-1:0]       address,
    output logic                                  rsp_valid,
    input  logic                                  rsp_stall,
    output logic                                  hit,
    output logic                                  writeback,
    output logic [sactc_pkg::LAT_BITS-1:0]        latency,
    output logic [sactc_pkg::CNT_BITS-1:0]        load_count,
    output logic [sactc_pkg::CNT_BITS-1:0]        store_count,
    output logic [sactc_pkg::CNT_BITS-1:0]        load_miss_count,
    output logic [sactc_pkg::CNT_BITS-1:0]        store_miss_count,
    output logic [sactc_pkg::CNT_BITS-1:0]        writeback_count
);
    import sactc_pkg::*;

    cfg_t       cfg;
    dp_cmd_t    cmd;
    dp_status_t status;

    // Configuration registers.
    sactc_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Controller.
    sactc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .status    (status),
        .cmd       (cmd)
    );

    // Datapath.
    sactc_datapath #(
        .NUM_SETS    (NUM_SETS),
        .NUM_WAYS    (NUM_WAYS),
        .BLOCK_BYTES (BLOCK_BYTES)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .status           (status),
        .cfg              (cfg),
        .operation        (operation),
        .address          (address),
        .rsp_valid        (rsp_valid),
        .rsp_stall        (rsp_stall),
        .hit              (hit),
        .writeback        (writeback),
        .latency          (latency),
        .load_count       (load_count),
        .store_count      (store_count),
        .load_miss_count  (load_miss_count),
        .store_miss_count (store_miss_count),
        .writeback_count  (writeback_count)
    );

endmodule

[design/sactc_cfg_regs.sv]
// APB-style configuration registers of the cache tag controller.
module sactc_cfg_regs (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [sactc_pkg::CFG_ADDR_BITS-1:0]   paddr,
    input  logic [sactc_pkg::CFG_DATA_BITS-1:0]   pwdata,
    output logic [sactc_pkg::CFG_DATA_BITS-1:0]   prdata,
    output logic                                  pready,
    output sactc_pkg::cfg_t                       cfg
);
    import sactc_pkg::*;

    logic                enable_reg;
    logic [LAT_BITS-1:0] lookup_lat_reg;
    logic [LAT_BITS-1:0] read_lat_reg;
    logic [LAT_BITS-1:0] write_lat_reg;
    logic                wr_en;
    cfg_reg_t            reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_sel = cfg_reg_t'(paddr[CFG_ADDR_BITS-1:2]);

    // Register writes in the access phase of a write transfer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg     <= RST_ENABLE;
            lookup_lat_reg <= RST_LOOKUP_LAT;
            read_lat_reg   <= RST_READ_LAT;
            write_lat_reg  <= RST_WRITE_LAT;
        end
        else if (wr_en)
        begin
            unique case (reg_sel)
                REG_ENABLE:     enable_reg     <= pwdata[0];
                REG_LOOKUP_LAT: lookup_lat_reg <= pwdata[LAT_BITS-1:0];
                REG_READ_LAT:   read_lat_reg   <= pwdata[LAT_BITS-1:0];
                REG_WRITE_LAT:  write_lat_reg  <= pwdata[LAT_BITS-1:0];
                default:        ;
            endcase
        end
    end

    // Read data, zero-extended to the bus width.
    always_comb
    begin
        unique case (reg_sel)
            REG_ENABLE:     prdata = CFG_DATA_BITS'(enable_reg);
            REG_LOOKUP_LAT: prdata = CFG_DATA_BITS'(lookup_lat_reg);
            REG_READ_LAT:   prdata = CFG_DATA_BITS'(read_lat_reg);
            REG_WRITE_LAT:  prdata = CFG_DATA_BITS'(write_lat_reg);
            default:        prdata = '0;
        endcase
    end

    assign cfg.enable     = enable_reg;
    assign cfg.lookup_lat = lookup_lat_reg;
    assign cfg.read_lat   = read_lat_reg;
    assign cfg.write_lat  = write_lat_reg;

endmodule

[design/sactc_ctrl.sv]
// Controller state machine: clearing pass, request acceptance and result commit.
module sactc_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    output logic                  req_stall,
    input  sactc_pkg::dp_status_t status,
    output sactc_pkg::dp_cmd_t    cmd
);
    import sactc_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    // State register; reset starts the clearing pass.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and datapath commands.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_stall  = 1'b1;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_en = 1'b1;
                if (status.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                req_stall = 1'b0;
                if (req_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                if (!status.out_blocked)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // An accepted transfer always moves on to the lookup step and blocks the next one.
    a_accept_to_lookup: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |=> (state_reg == ST_LOOKUP) && req_stall)
        else $error("accepted transfer did not enter lookup");

    // A full result register holds the lookup step until the result is taken.
    a_hold_on_block: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LOOKUP && status.out_blocked) |=> (state_reg == ST_LOOKUP))
        else $error("lookup left while result register was blocked");

    // No request is taken while the clearing pass runs.
    a_clear_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clear_en |-> (req_stall && !cmd.capture && !cmd.commit))
        else $error("request accepted during clearing pass");

endmodule

[design/sactc_datapath.sv]
// Datapath: tag and line-state arrays, hit and victim logic, counters and result register.
module sactc_datapath #(
    parameter int NUM_SETS    = 8,
    parameter int NUM_WAYS    = 4,
    parameter int BLOCK_BYTES = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  sactc_pkg::dp_cmd_t                cmd,
    output sactc_pkg::dp_status_t             status,
    input  sactc_pkg::cfg_t                   cfg,
    input  logic                              operation,
    input  logic [sactc_pkg::ADDR_BITS-1:0]   address,
    output logic                              rsp_valid,
    input  logic                              rsp_stall,
    output logic                              hit,
    output logic                              writeback,
    output logic [sactc_pkg::LAT_BITS-1:0]    latency,
    output logic [sactc_pkg::CNT_BITS-1:0]    load_count,
    output logic [sactc_pkg::CNT_BITS-1:0]    store_count,
    output logic [sactc_pkg::CNT_BITS-1:0]    load_miss_count,
    output logic [sactc_pkg::CNT_BITS-1:0]    store_miss_count,
    output logic [sactc_pkg::CNT_BITS-1:0]    writeback_count
);
    import sactc_pkg::*;

    localparam int OFFSET_BITS  = $clog2(BLOCK_BYTES);
    localparam int SET_BITS     = $clog2(NUM_SETS);
    localparam int TAG_BITS     = ADDR_BITS - OFFSET_BITS - SET_BITS;
    localparam int WAY_BITS     = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
    localparam int META_BITS    = WAY_BITS + 2 * NUM_WAYS;
    localparam int ROW_TAG_BITS = NUM_WAYS * TAG_BITS;
    localparam logic [WAY_BITS-1:0] LAST_WAY = WAY_BITS'(NUM_WAYS - 1);
    localparam logic [SET_BITS-1:0] LAST_SET = SET_BITS'(NUM_SETS - 1);

    // One row per set: all way tags, and pointer plus valid and dirty bits.
    logic [ROW_TAG_BITS-1:0] tag_mem  [NUM_SETS];
    logic [META_BITS-1:0]    meta_mem [NUM_SETS];

    logic [SET_BITS-1:0]     in_set;
    logic [TAG_BITS-1:0]     in_tag;
    logic                    store_reg;
    logic [TAG_BITS-1:0]     tag_reg;
    logic [SET_BITS-1:0]     set_reg;
    logic [ROW_TAG_BITS-1:0] tag_row_reg;
    logic [META_BITS-1:0]    meta_row_reg;
    logic [SET_BITS-1:0]     clr_cnt_reg;

    logic [WAY_BITS-1:0]     ptr;
    logic [NUM_WAYS-1:0]     valid_row;
    logic [NUM_WAYS-1:0]     dirty_row;
    logic [NUM_WAYS-1:0]     match;
    logic [NUM_WAYS-1:0]     first_hit;
    logic [NUM_WAYS-1:0]     vict_oh;
    logic                    is_hit;
    logic                    is_wb;
    logic [WAY_BITS-1:0]     ptr_next;
    logic [NUM_WAYS-1:0]     valid_next;
    logic [NUM_WAYS-1:0]     dirty_next;
    logic [ROW_TAG_BITS-1:0] tag_row_next;
    logic [META_BITS-1:0]    meta_next;
    logic [LAT_BITS-1:0]     lat_next;
    logic                    active;

    logic                    rsp_valid_reg;
    logic                    hit_reg;
    logic                    writeback_reg;
    logic [LAT_BITS-1:0]     latency_reg;
    logic [CNT_BITS-1:0]     loads_reg;
    logic [CNT_BITS-1:0]     stores_reg;
    logic [CNT_BITS-1:0]     ld_miss_cnt_reg;
    logic [CNT_BITS-1:0]     st_miss_cnt_reg;
    logic [CNT_BITS-1:0]     writebacks_reg;

    assign in_set = address[OFFSET_BITS +: SET_BITS];
    assign in_tag = address[ADDR_BITS-1 -: TAG_BITS];
    assign active = cmd.commit && cfg.enable;

    // Capture the request and read its set row on the accepting edge.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            store_reg    <= (operation == OP_STORE);
            tag_reg      <= in_tag;
            set_reg      <= in_set;
            tag_row_reg  <= tag_mem[in_set];
            meta_row_reg <= meta_mem[in_set];
        end
    end

    // Array writes: clearing pass over the line state, then updates on commit while the cache is enabled.
    always_ff @(posedge clk)
    begin
        if (cmd.clear_en)
        begin
            meta_mem[clr_cnt_reg] <= '0;
        end
        else if (active)
        begin
            meta_mem[set_reg] <= meta_next;
            tag_mem[set_reg]  <= tag_row_next;
        end
    end

    // Clearing pass counter, one set per cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else if (cmd.clear_en)
        begin
            clr_cnt_reg <= clr_cnt_reg + SET_BITS'(1);
        end
    end

    // Tag compare, hit way, victim selection and the updated row.
    always_comb
    begin
        ptr       = meta_row_reg[META_BITS-1 -: WAY_BITS];
        valid_row = meta_row_reg[2*NUM_WAYS-1:NUM_WAYS];
        dirty_row = meta_row_reg[NUM_WAYS-1:0];
        for (int w = 0; w < NUM_WAYS; w++)
        begin
            match[w] = valid_row[w] && (tag_row_reg[w*TAG_BITS +: TAG_BITS] == tag_reg);
        end
        // The lowest matching way wins.
        first_hit = match & (~match + NUM_WAYS'(1));
        is_hit    = |match;
        vict_oh   = NUM_WAYS'(1) << ptr;
        is_wb     = !is_hit && |(dirty_row & vict_oh);

        tag_row_next = tag_row_reg;
        if (is_hit)
        begin
            ptr_next   = ptr;
            valid_next = valid_row;
            dirty_next = store_reg ? (dirty_row | first_hit) : dirty_row;
        end
        else
        begin
            ptr_next   = (ptr == LAST_WAY) ? '0 : ptr + WAY_BITS'(1);
            valid_next = valid_row | vict_oh;
            dirty_next = store_reg ? (dirty_row | vict_oh) : (dirty_row & ~vict_oh);
            for (int w = 0; w < NUM_WAYS; w++)
            begin
                if (vict_oh[w])
                begin
                    tag_row_next[w*TAG_BITS +: TAG_BITS] = tag_reg;
                end
            end
        end
        meta_next = {ptr_next, valid_next, dirty_next};

        // Reported latency.
        if (!cfg.enable)
        begin
            lat_next = store_reg ? cfg.write_lat : cfg.read_lat;
        end
        else
        begin
            lat_next = is_hit ? cfg.lookup_lat : cfg.write_lat;
        end
    end

    // Access counters, changed only while the cache is modeled.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            loads_reg       <= '0;
            stores_reg      <= '0;
            ld_miss_cnt_reg <= '0;
            st_miss_cnt_reg <= '0;
            writebacks_reg  <= '0;
        end
        else if (active)
        begin
            if (store_reg)
            begin
                stores_reg <= stores_reg + CNT_BITS'(1);
                if (!is_hit)
                begin
                    st_miss_cnt_reg <= st_miss_cnt_reg + CNT_BITS'(1);
                end
            end
            else
            begin
                loads_reg <= loads_reg + CNT_BITS'(1);
                if (!is_hit)
                begin
                    ld_miss_cnt_reg <= ld_miss_cnt_reg + CNT_BITS'(1);
                end
            end
            if (is_wb)
            begin
                writebacks_reg <= writebacks_reg + CNT_BITS'(1);
            end
        end
    end

    // Result register valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (cmd.commit)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            hit_reg       <= cfg.enable && is_hit;
            writeback_reg <= cfg.enable && is_wb;
            latency_reg   <= lat_next;
        end
    end

    assign status.clear_last  = (clr_cnt_reg == LAST_SET);
    assign status.out_blocked = rsp_valid_reg && rsp_stall;

    assign rsp_valid        = rsp_valid_reg;
    assign hit              = hit_reg;
    assign writeback        = writeback_reg;
    assign latency          = latency_reg;
    assign load_count       = loads_reg;
    assign store_count      = stores_reg;
    assign load_miss_count  = ld_miss_cnt_reg;
    assign store_miss_count = st_miss_cnt_reg;
    assign writeback_count  = writebacks_reg;

    // A result is never written over one that is still waiting.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> !(rsp_valid_reg && rsp_stall))
        else $error("result register overwritten while stalled");

    // A hit never evicts a line.
    a_hit_no_wb: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg |-> !(hit_reg && writeback_reg))
        else $error("hit reported together with writeback");

    // With the cache bypassed the counters hold.
    a_bypass_counters: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.commit && !cfg.enable) |=> ($stable(loads_reg) && $stable(stores_reg)
            && $stable(writebacks_reg)))
        else $error("counter changed while the cache was bypassed");

endmodule
